@@ sv/point_density_ascii_raster_unit_macros.svh @@
// Assertion macros shared by the raster unit.
`ifndef POINT_DENSITY_ASCII_RASTER_UNIT_MACROS_SVH
`define POINT_DENSITY_ASCII_RASTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PDAR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdar assertion failed");

// Next-cycle implication, disabled during reset.
`define PDAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdar assertion failed");

`endif

@@ sv/pdar_pkg.sv @@
package pdar_pkg;

  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 32;

  localparam int COORD_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int COLS_W    = 6;
  localparam int ROWS_W    = 7;
  localparam int ROWSEL_W  = 6;
  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int COUNT_W   = 8;
  localparam int STEP_W    = 5;
  localparam int IN_DATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd3;

  localparam logic [COORD_W-1:0] CELL_SIZE_RST   = 32'h0001_0000;
  localparam logic [COLS_W-1:0]  COLS_IN_USE_RST = 6'd32;
  localparam logic [ROWS_W-1:0]  ROWS_IN_USE_RST = 7'd32;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POINT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RENDER = 2'd2;

  localparam logic [COUNT_W-1:0] MARK_HIGH = 8'd3;
  localparam logic [COUNT_W-1:0] MARK_MID  = 8'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PT_READ,
    ST_PT_WRITE,
    ST_RD,
    ST_EMIT,
    ST_NL
  } state_t;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic div_start;
    logic row_load;
    logic pt_read;
    logic pt_write;
    logic rd_read;
    logic emit_char;
    logic emit_nl;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pt_drop;
    logic row_ok;
    logic cols_zero;
    logic div_busy;
    logic pt_in_range;
    logic col_last;
    logic out_free;
    logic clr_last;
  } dp_sts_t;

  function automatic logic [CHAR_W-1:0] mark_of(input logic [COUNT_W-1:0] n);
    logic [CHAR_W-1:0] ch;
    if (n > MARK_HIGH) ch = CH_HASH;
    else if (n > MARK_MID) ch = CH_STAR;
    else if (n != '0) ch = CH_DOT;
    else ch = CH_SPACE;
    return ch;
  endfunction

endpackage

@@ sv/pdar_div.sv @@
module pdar_div
  import pdar_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] dividend,
  input  logic [COORD_W-1:0] divisor,
  output logic               busy,
  output logic [COORD_W-1:0] quotient
);

  logic [COORD_W-1:0] rem;
  logic [COORD_W-1:0] dq;
  logic [COORD_W-1:0] dvs;
  logic [STEP_W-1:0]  step;
  logic [COORD_W:0]   shifted;
  logic [COORD_W:0]   diff;
  logic               ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem, dq[COORD_W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      rem  <= '0;
      dq   <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
      dq   <= {dq[COORD_W-2:0], ge};
      step <= step + 1'b1;
      if (step == STEP_W'(COORD_W - 1)) busy <= 1'b0;
    end
  end

  assign quotient = dq;

endmodule

@@ sv/pdar_dpath.sv @@
module pdar_dpath
  import pdar_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [COORD_W-1:0]   point_x,
  input  logic [COORD_W-1:0]   point_y,
  input  logic [ROWSEL_W-1:0]  row_select,
  input  ctrl_cmd_t            cmd,
  output dp_sts_t              sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [CHAR_W-1:0]    out_char,
  output logic                 out_last
);

  localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FULL_W = ROWSEL_W + COLS_W + 1;

  logic [COORD_W-1:0]  cell_width;
  logic [COORD_W-1:0]  cell_height;
  logic [COLS_W-1:0]   cols_in_use;
  logic [ROWS_W-1:0]   rows_in_use;
  logic [COLS_W-1:0]   cols_active;
  logic [ROWS_W-1:0]   rows_active;

  logic [AW-1:0]       clr_addr;
  logic [ROWSEL_W-1:0] row_reg;
  logic [COLS_W-1:0]   col;

  logic [COUNT_W-1:0]  mem [DEPTH];
  logic [COUNT_W-1:0]  rdata;

  logic [COORD_W-1:0]  qx;
  logic [COORD_W-1:0]  qy;
  logic                busy_x;
  logic                busy_y;

  logic [AW-1:0]       pt_addr;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [COUNT_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width  <= CELL_SIZE_RST;
      cell_height <= CELL_SIZE_RST;
      cols_in_use <= COLS_IN_USE_RST;
      rows_in_use <= ROWS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_WIDTH:  cell_width  <= cfg_wdata;
        REG_CELL_HEIGHT: cell_height <= cfg_wdata;
        REG_COLS_IN_USE: cols_in_use <= cfg_wdata[COLS_W-1:0];
        REG_ROWS_IN_USE: rows_in_use <= cfg_wdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_active = (cols_in_use < COLS_W'(GRID_WIDTH)) ? cols_in_use : COLS_W'(GRID_WIDTH);
    rows_active = (rows_in_use < ROWS_W'(GRID_HEIGHT)) ? rows_in_use : ROWS_W'(GRID_HEIGHT);
  end

  pdar_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (point_x),
    .divisor  (cell_width),
    .busy     (busy_x),
    .quotient (qx)
  );

  pdar_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (point_y),
    .divisor  (cell_height),
    .busy     (busy_y),
    .quotient (qy)
  );

  // Address is only used once the quotients are known to lie in the grid
  always_comb begin
    pt_addr = AW'(FULL_W'(qy[ROWSEL_W-1:0]) * FULL_W'(GRID_WIDTH)
                  + FULL_W'(qx[COLS_W-1:0]));
    rd_addr = AW'(FULL_W'(row_reg) * FULL_W'(GRID_WIDTH) + FULL_W'(col));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      row_reg <= row_select;
      col     <= '0;
    end else if (cmd.emit_char) begin
      col <= col + 1'b1;
    end
  end

  always_comb begin
    mem_we    = cmd.clr_step | cmd.pt_write;
    mem_waddr = cmd.clr_step ? clr_addr : pt_addr;
    if (cmd.clr_step) mem_wdata = '0;
    else if (rdata == COUNT_MAX) mem_wdata = rdata;
    else mem_wdata = rdata + 1'b1;
    mem_re    = cmd.pt_read | cmd.rd_read;
    mem_raddr = cmd.pt_read ? pt_addr : rd_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_char || cmd.emit_nl) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_char) begin
      out_char <= mark_of(rdata);
      out_last <= 1'b0;
    end else if (cmd.emit_nl) begin
      out_char <= CH_NL;
      out_last <= 1'b1;
    end
  end

  always_comb begin
    sts.pt_drop     = point_x[COORD_W-1] | point_y[COORD_W-1]
                      | (cell_width == '0) | (cell_height == '0);
    sts.row_ok      = ({1'b0, row_select} < rows_active);
    sts.cols_zero   = (cols_active == '0);
    sts.div_busy    = busy_x | busy_y;
    sts.pt_in_range = (qx < COORD_W'(cols_active)) && (qy < COORD_W'(rows_active));
    sts.col_last    = (col == cols_active - 1'b1);
    sts.out_free    = !out_valid || out_ready;
    sts.clr_last    = (clr_addr == AW'(DEPTH - 1));
  end

endmodule

@@ sv/pdar_ctrl.sv @@
module pdar_ctrl
  import pdar_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  dp_sts_t          sts,
  output ctrl_cmd_t        cmd
);

  state_t state;
  state_t state_next;

  // Reset starts with a sweep that zeroes the grid
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = ST_CLEAR;
            end
            CMD_POINT: begin
              if (!sts.pt_drop) begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
              end
            end
            CMD_RENDER: begin
              if (sts.row_ok) begin
                cmd.row_load = 1'b1;
                state_next   = sts.cols_zero ? ST_NL : ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) state_next = ST_PT_READ;
      end
      ST_PT_READ: begin
        if (sts.pt_in_range) begin
          cmd.pt_read = 1'b1;
          state_next  = ST_PT_WRITE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PT_WRITE: begin
        cmd.pt_write = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_RD: begin
        cmd.rd_read = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        // hold the fetched count until the output register frees up
        if (sts.out_free) begin
          cmd.emit_char = 1'b1;
          state_next    = sts.col_last ? ST_NL : ST_RD;
        end
      end
      ST_NL: begin
        if (sts.out_free) begin
          cmd.emit_nl = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ sv/point_density_ascii_raster_unit.sv @@
// Point density raster: a grid of 8-bit hit counts drawn as ASCII text.
// Input stream s_axis_*: tuser carries the command (clear, add point,
// render row); tdata carries point_x, point_y and row_select.
// Output stream m_axis_*: one character per item; tlast marks the newline
// that ends a rendered row. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_wdata); the user must use it only while the block
// is idle, and the block itself does not enforce this. Add point: both
// coordinates go through two bit-serial dividers side by side, one quotient
// bit a cycle, then a read and a write of the count; a cell outside the grid
// in use skips the read and the write. A negative coordinate or a zero cell
// size drops the point. Clear: one grid entry zeroed a cycle through the
// single write port of the grid, covering all GRID_WIDTH * GRID_HEIGHT
// entries (1024 at the default size). Render: for each character a grid
// read, then a load of the output register, and after the last one the
// newline. Reset runs the same clearing sweep before the first item is taken.
// A stalled receiver holds the current character in the output register and
// the render pauses; nothing is lost. A new item may be accepted while the
// last character of a row still waits to be taken.
module point_density_ascii_raster_unit
  import pdar_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // point_x, point_y, row_select, zero pad
  input  logic [CMD_W-1:0]     s_axis_tuser,   // cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [CHAR_W-1:0]    m_axis_tdata,   // char_code
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  `include "point_density_ascii_raster_unit_macros.svh"

  ctrl_cmd_t           cmd;
  dp_sts_t             sts;
  logic [COORD_W-1:0]  point_x;
  logic [COORD_W-1:0]  point_y;
  logic [ROWSEL_W-1:0] row_select;

  assign point_x    = s_axis_tdata[COORD_W-1:0];
  assign point_y    = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign row_select = s_axis_tdata[2*COORD_W+ROWSEL_W-1:2*COORD_W];

  pdar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdar_dpath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .point_x    (point_x),
    .point_y    (point_y),
    .row_select (row_select),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_char   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

  // the row-ending item is always the newline
  `PDAR_ASSERT_IMPL(a_last_is_nl, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata == CH_NL)

  // an accepted clear starts the sweep, so no item is taken next cycle
  `PDAR_ASSERT_NEXT(a_clear_blocks, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_CLEAR, !s_axis_tready)

  // characters are loaded only while a render runs, never while idle
  `PDAR_ASSERT_IMPL(a_emit_in_render, clk, rst, m_axis_tvalid && !$past(m_axis_tvalid), !$past(s_axis_tready))

endmodule
